// ----- design/sfc_pkg.sv -----
// shared constants, types and codes for the space filling curve point unit
// no dependencies; imported by every other file of the block
package sfc_pkg;

    localparam int MAX_LEVEL = 10;

    localparam int LVL_W     = 4;
    localparam int IDX_W     = 23;
    localparam int COORD_W   = 12;
    localparam int FACE_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    // per face offset and per axis cell widths
    localparam int OFF_W  = 2 * MAX_LEVEL;
    localparam int CELL_W = MAX_LEVEL;
    // wide enough for the index and for six times the per face count
    localparam int WIDE_W = (IDX_W > OFF_W + 3) ? IDX_W : OFF_W + 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE  = CFG_IDX_W'(1);

    localparam logic [LVL_W-1:0] RESET_LEVEL = LVL_W'(4);
    localparam logic             RESET_CUBE  = 1'b1;

    // quadrant digits of one level
    localparam logic [1:0] QUAD_LL = 2'd0;
    localparam logic [1:0] QUAD_UL = 2'd1;
    localparam logic [1:0] QUAD_UR = 2'd2;
    localparam logic [1:0] QUAD_LR = 2'd3;

    // cube faces by the axis and side they sit on
    localparam logic [FACE_W-1:0] FACE_YP = FACE_W'(0);
    localparam logic [FACE_W-1:0] FACE_XP = FACE_W'(1);
    localparam logic [FACE_W-1:0] FACE_ZN = FACE_W'(2);
    localparam logic [FACE_W-1:0] FACE_XN = FACE_W'(3);
    localparam logic [FACE_W-1:0] FACE_ZP = FACE_W'(4);
    localparam logic [FACE_W-1:0] FACE_LAST = FACE_W'(5);

    typedef logic [MAX_LEVEL-1:0][1:0] t_digits;

    // one item on its way through the level stages
    typedef struct packed {
        logic              in_range;
        logic              cube;
        logic [FACE_W-1:0] face;
        logic [LVL_W-1:0]  lvl;
        t_digits           dig;
        logic [CELL_W-1:0] u;
        logic [CELL_W-1:0] v;
    } t_cell;

endpackage

// ----- design/sfc_intf.sv -----
// channel interfaces of the space filling curve point unit: point in, point out, config
// depends on sfc_pkg
interface sfc_in_if;
    import sfc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] point_index;

    modport source (output valid, output point_index, input ready);
    modport sink   (input valid, input point_index, output ready);
endinterface

interface sfc_out_if;
    import sfc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [FACE_W-1:0]         face_number;
    logic                      in_range;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output face_number, output in_range, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input face_number, input in_range, output ready);
endinterface

interface sfc_cfg_if;
    import sfc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- design/sfc_front.sv -----
// front end: range check, face split, offset reversal, then quadrant digits
// depends on sfc_pkg
module sfc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sfc_pkg::IDX_W-1:0]     i_index,
    input  logic [sfc_pkg::LVL_W-1:0]     i_level,
    input  logic                          i_cube,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sfc_pkg::t_cell                o_item
);
    import sfc_pkg::*;

    // stage a: decoded item
    logic              r_a_valid;
    logic              r_a_in_range;
    logic              r_a_cube;
    logic [FACE_W-1:0] r_a_face;
    logic [LVL_W-1:0]  r_a_lvl;
    logic [OFF_W-1:0]  r_a_off;

    logic              n_a_in_range;
    logic [FACE_W-1:0] n_a_face;
    logic [LVL_W-1:0]  n_a_lvl;
    logic [OFF_W-1:0]  n_a_off;

    logic              r_b_valid;
    t_cell             r_b_item;
    t_cell             n_b_item;

    logic              a_ready;
    logic              b_ready;

    logic [LVL_W:0]    shift;
    logic [WIDE_W-1:0] per_face;
    logic [WIDE_W-1:0] count;
    logic [WIDE_W-1:0] idx_w;
    logic [WIDE_W-1:0] face_w;
    logic [OFF_W-1:0]  mask;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        n_a_lvl  = (i_level > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : i_level;
        shift    = {n_a_lvl, 1'b0};
        per_face = WIDE_W'(1) << shift;
        count    = i_cube ? ((per_face << 2) + (per_face << 1)) : per_face;
        idx_w    = WIDE_W'(i_index);
        n_a_in_range = idx_w < count;
        face_w   = idx_w >> shift;
        n_a_face = (n_a_in_range && i_cube) ? FACE_W'(face_w) : '0;
        mask     = OFF_W'(per_face - WIDE_W'(1));
        n_a_off  = OFF_W'(idx_w) & mask;
        // faces past the second run the curve backwards
        if (i_cube && n_a_face >= FACE_ZN) begin
            n_a_off = ~n_a_off & mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready) begin
            r_a_in_range <= n_a_in_range;
            r_a_cube     <= i_cube;
            r_a_face     <= n_a_face;
            r_a_lvl      <= n_a_lvl;
            r_a_off      <= n_a_off;
        end
    end

    // stage b: digits from the top, complementing below quadrants ll and lr
    always_comb begin
        logic [1:0] flip;
        logic [1:0] q;
        flip = 2'b00;
        q    = 2'b00;
        n_b_item.in_range = r_a_in_range;
        n_b_item.cube     = r_a_cube;
        n_b_item.face     = r_a_face;
        n_b_item.lvl      = r_a_lvl;
        n_b_item.u        = '0;
        n_b_item.v        = '0;
        n_b_item.dig      = '0;
        for (int k = MAX_LEVEL; k >= 1; k--) begin
            q = r_a_off[2*(k-1) +: 2] ^ flip;
            if (LVL_W'(k) <= r_a_lvl) begin
                n_b_item.dig[k-1] = q;
                if (q == QUAD_LL || q == QUAD_LR) begin
                    flip = flip ^ 2'b11;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ----- design/sfc_level_pipe.sv -----
// one register stage per curve level, lowest level first, placing the cell
// depends on sfc_pkg
module sfc_level_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sfc_pkg::t_cell i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output sfc_pkg::t_cell o_item
);
    import sfc_pkg::*;

    function automatic t_cell level_step(input t_cell c, input int k);
        t_cell             r;
        logic [CELL_W-1:0] s;
        logic [1:0]        q;
        r = c;
        s = CELL_W'(1) << (k - 1);
        q = c.dig[k-1];
        if (LVL_W'(k) <= c.lvl) begin
            unique case (q)
                QUAD_LL: begin
                    r.u = c.v;
                    r.v = s - CELL_W'(1) - c.u;
                end
                QUAD_UL: begin
                    r.u = c.u;
                    r.v = c.v + s;
                end
                QUAD_UR: begin
                    r.u = c.u + s;
                    r.v = c.v + s;
                end
                QUAD_LR: begin
                    // wraps to all ones at the top level, still exact mod 2^CELL_W
                    r.u = (s << 1) - CELL_W'(1) - c.v;
                    r.v = c.u;
                end
            endcase
        end
        return r;
    endfunction

    logic  [MAX_LEVEL-1:0] r_valid;
    t_cell                 r_item [MAX_LEVEL];
    logic  [MAX_LEVEL:0]   rdy;

    assign rdy[MAX_LEVEL] = i_ready;
    assign o_ready        = rdy[0];

    for (genvar j = 0; j < MAX_LEVEL; j++) begin : g_stage
        t_cell src;
        logic  src_valid;

        assign rdy[j] = !r_valid[j] || rdy[j+1];

        if (j == 0) begin : g_first
            assign src       = i_item;
            assign src_valid = i_valid;
        end else begin : g_next
            assign src       = r_item[j-1];
            assign src_valid = r_valid[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_valid[j] <= src_valid;
            end
            if (rdy[j]) begin
                r_item[j] <= level_step(src, j + 1);
            end
        end
    end

    assign o_valid = r_valid[MAX_LEVEL-1];
    assign o_item  = r_item[MAX_LEVEL-1];

endmodule

// ----- design/sfc_map.sv -----
// output stage: scaled coordinates, cube face placement, output register
// depends on sfc_pkg
module sfc_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  sfc_pkg::t_cell                    i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [sfc_pkg::COORD_W-1:0] o_x,
    output logic signed [sfc_pkg::COORD_W-1:0] o_y,
    output logic signed [sfc_pkg::COORD_W-1:0] o_z,
    output logic [sfc_pkg::FACE_W-1:0]        o_face,
    output logic                              o_in_range
);
    import sfc_pkg::*;

    logic                      r_valid;
    logic signed [COORD_W-1:0] r_x, r_y, r_z, r_n;
    logic [FACE_W-1:0]         r_face;
    logic                      r_in_range;
    logic                      r_cube;

    logic signed [COORD_W-1:0] n_x, n_y, n_z, n_n;
    logic [FACE_W-1:0]         n_face;

    logic signed [COORD_W-1:0] px, py;
    logic                      ready;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;

    always_comb begin
        n_n = COORD_W'(1) << i_item.lvl;
        px  = COORD_W'({i_item.u, 1'b1}) - n_n;
        py  = COORD_W'({i_item.v, 1'b1}) - n_n;
        n_face = i_item.face;
        n_x = px;
        n_y = py;
        n_z = '0;
        if (i_item.cube) begin
            unique case (i_item.face)
                FACE_YP: begin n_x = px;   n_y = n_n;  n_z = py;   end
                FACE_XP: begin n_x = n_n;  n_y = -px;  n_z = py;   end
                FACE_ZN: begin n_x = px;   n_y = py;   n_z = -n_n; end
                FACE_XN: begin n_x = -n_n; n_y = py;   n_z = -px;  end
                FACE_ZP: begin n_x = -px;  n_y = py;   n_z = n_n;  end
                default: begin n_x = px;   n_y = -n_n; n_z = -py;  end
            endcase
        end else begin
            n_face = '0;
        end
        if (!i_item.in_range) begin
            n_x    = '0;
            n_y    = '0;
            n_z    = '0;
            n_face = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
        if (ready) begin
            r_x        <= n_x;
            r_y        <= n_y;
            r_z        <= n_z;
            r_n        <= n_n;
            r_face     <= n_face;
            r_in_range <= i_item.in_range;
            r_cube     <= i_item.cube;
        end
    end

    assign o_valid    = r_valid;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_z        = r_z;
    assign o_face     = r_face;
    assign o_in_range = r_in_range;

`ifndef SYNTHESIS
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_in_range |-> r_x == '0 && r_y == '0 && r_z == '0 && r_face == '0)
        else $error("out of range point carries nonzero fields");

    a_plane_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_in_range && !r_cube |-> r_z == '0 && r_face == '0)
        else $error("plane point off the z plane or with a face");

    a_cube_face_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_in_range && r_cube |-> r_face <= FACE_LAST)
        else $error("cube point with face past the last one");

    a_cube_on_surface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_in_range && r_cube |->
            r_x == r_n || r_x == -r_n || r_y == r_n || r_y == -r_n ||
            r_z == r_n || r_z == -r_n)
        else $error("cube point not on a face");

    a_odd_cell_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_in_range && !r_cube && r_n != COORD_W'(1) |-> r_x[0] && r_y[0])
        else $error("plane point not at a cell center");
`endif

endmodule

// ----- design/space_filling_curve_point_unit.sv -----
// top level of the space filling curve point unit: config registers and the pipeline
// depends on sfc_pkg, sfc_intf, sfc_front, sfc_level_pipe, sfc_map
//
// maps a point index to the matching point of a hilbert-type curve of depth
// curve_level (n = 2^level cells a side), either on the plane (z zero, face zero)
// or wrapped over six cube faces sitting at +-n. coordinates are scaled by n:
// cell (u,v) gives 2u+1-n, 2v+1-n. in cube mode the index is face * 4^level plus
// the offset within the face, and faces two to five walk their offsets backwards.
// an index at or past the point count comes out with in_range low and all other
// fields zero. curve_level above the maximum level saturates at it.
// throughput: one beat per cycle on both channels while the output takes beats. the pipe
// holds two front stages (decode and digit extraction), one register stage per curve level
// and the output register. every stage has its own valid bit and local ready, so bubbles
// close up and the input keeps taking beats while a finished point waits at the output,
// as long as some stage ahead of it is still empty.
// config: the write channel is always ready; index 0 is curve_level, index 1 is
// cube_mode. write only when no point is in flight; reset gives level 4, cube on.
module space_filling_curve_point_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfc_in_if.sink    i_pt,
    sfc_out_if.source o_pt,
    sfc_cfg_if.sink   i_cfg
);
    import sfc_pkg::*;

    // config registers
    logic [LVL_W-1:0] r_level;
    logic             r_cube;

    // front to level stages
    logic  front_valid;
    logic  front_ready;
    t_cell front_item;

    // level stages to output stage
    logic  cell_valid;
    logic  cell_ready;
    t_cell cell_item;

    // config beats are taken every cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= RESET_LEVEL;
            r_cube  <= RESET_CUBE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_LEVEL: r_level <= i_cfg.wr_data[LVL_W-1:0];
                CFG_CUBE:  r_cube  <= i_cfg.wr_data[0];
            endcase
        end
    end

    // decode and quadrant digits
    sfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pt.valid),
        .o_ready (i_pt.ready),
        .i_index (i_pt.point_index),
        .i_level (r_level),
        .i_cube  (r_cube),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    // one stage per level builds the cell position
    sfc_level_pipe u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (cell_valid),
        .i_ready (cell_ready),
        .o_item  (cell_item)
    );

    // scaling, face placement and output register
    sfc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (cell_valid),
        .o_ready    (cell_ready),
        .i_item     (cell_item),
        .o_valid    (o_pt.valid),
        .i_ready    (o_pt.ready),
        .o_x        (o_pt.coord_x),
        .o_y        (o_pt.coord_y),
        .o_z        (o_pt.coord_z),
        .o_face     (o_pt.face_number),
        .o_in_range (o_pt.in_range)
    );

endmodule

// ----- tb/sv/space_filling_curve_point_unit_tb.sv -----
// self-checking testbench of the space filling curve point unit: directed table, then random
// phases under several level and cube settings, every beat checked against a local predictor
// depends on sfc_pkg, sfc_intf and the rtl of space_filling_curve_point_unit
module space_filling_curve_point_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 9;
    localparam int          IDLE_PCT     = 13;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          NUM_PHASES   = 14;
    localparam int          PHASE_ITEMS  = 75;
    localparam int          NO_IDLE_PHASE = 2;
    localparam int          HOLD_PHASE   = 4;
    localparam int          REPORT_MAX   = 10;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // pipeline depth of the unit, taken twice for the final drain
    localparam int          PIPE_DEPTH   = 3 + MAX_LEVEL;

    // one result beat
    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [FACE_W-1:0]         face_number;
        logic                      in_range;
    } t_point;

    // out of range: everything zero, in_range low
    localparam t_point MISS_PT = '0;

    // directed row: settings, index, and a typed-in result where one is obvious
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             cube;
        logic [IDX_W-1:0] idx;
        logic             typed;
        t_point           lit;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset settings (level 4, cube on) are used without a write first
        '{4'd4,  1'b1, 23'd0,       1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd1535,    1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd1536,    1'b1, MISS_PT},
        '{4'd4,  1'b1, 23'h7FFFFF,  1'b1, MISS_PT},
        '{4'd4,  1'b1, 23'd256,     1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd512,     1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd1023,    1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd1024,    1'b0, MISS_PT},
        '{4'd4,  1'b1, 23'd1280,    1'b0, MISS_PT},
        // level zero on the plane: one point at the origin
        '{4'd0,  1'b0, 23'd0,       1'b1, '{12'sd0, 12'sd0, 12'sd0, '0, 1'b1}},
        '{4'd0,  1'b0, 23'd1,       1'b1, MISS_PT},
        // level zero on the cube: face number is the index, point at the face center
        '{4'd0,  1'b1, 23'd0,       1'b1, '{12'sd0, 12'sd1, 12'sd0, FACE_YP, 1'b1}},
        '{4'd0,  1'b1, 23'd3,       1'b1, '{-12'sd1, 12'sd0, 12'sd0, FACE_XN, 1'b1}},
        '{4'd0,  1'b1, 23'd5,       1'b1, '{12'sd0, -12'sd1, 12'sd0, FACE_LAST, 1'b1}},
        '{4'd0,  1'b1, 23'd6,       1'b1, MISS_PT},
        // level one on the plane: one beat per quadrant
        '{4'd1,  1'b0, 23'd0,       1'b1, '{-12'sd1, -12'sd1, 12'sd0, '0, 1'b1}},
        '{4'd1,  1'b0, 23'd1,       1'b0, MISS_PT},
        '{4'd1,  1'b0, 23'd2,       1'b0, MISS_PT},
        '{4'd1,  1'b0, 23'd3,       1'b0, MISS_PT},
        '{4'd1,  1'b0, 23'd4,       1'b1, MISS_PT},
        // deepest level, then a level past the maximum that must saturate
        '{4'd10, 1'b0, 23'd1048575, 1'b0, MISS_PT},
        '{4'd10, 1'b0, 23'd1048576, 1'b1, MISS_PT},
        '{4'd15, 1'b1, 23'd6291455, 1'b0, MISS_PT},
        '{4'd15, 1'b1, 23'h7FFFFF,  1'b1, MISS_PT},
        '{4'd15, 1'b0, 23'd1048576, 1'b1, MISS_PT}
    };

    // fixed settings of the first random phases, extremes among them
    localparam logic [LVL_W-1:0] PHASE_LEVEL [8] = '{4'd10, 4'd0, 4'd10, 4'd15,
                                                      4'd3, 4'd0, 4'd1, 4'd15};
    localparam logic             PHASE_CUBE  [8] = '{1'b1, 1'b0, 1'b0, 1'b1,
                                                      1'b1, 1'b1, 1'b0, 1'b0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    sfc_in_if  pt_in ();
    sfc_out_if pt_out ();
    sfc_cfg_if cfg_wr ();

    space_filling_curve_point_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_in),
        .o_pt    (pt_out),
        .i_cfg   (cfg_wr)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // local copy of the two registers, updated as each write beat lands
    logic [LVL_W-1:0] lvl_shadow  = RESET_LEVEL;
    logic             cube_shadow = RESET_CUBE;

    // points expected at the output, oldest first
    t_point      pending_points [$];
    int unsigned bad_beats = 0;
    int unsigned cycle_count = 0;

    // random idling on both sides, and a request for one long output hold-off
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    // curve point of an index under the current shadow settings
    function automatic t_point plot_point(input logic [IDX_W-1:0] idx);
        int unsigned       lvl;
        int unsigned       face;
        int unsigned       k;
        longint unsigned   per_face;
        longint unsigned   count;
        longint unsigned   off;
        logic [1:0]        quad [1:MAX_LEVEL];
        logic [1:0]        flip;
        logic [1:0]        q;
        longint            u, v, nu, nv, s, n, px, py, cx, cy, cz;
        t_point            r;

        lvl = (lvl_shadow > MAX_LEVEL) ? MAX_LEVEL : lvl_shadow;
        per_face = longint'(1) << (2 * lvl);
        count = cube_shadow ? 6 * per_face : per_face;
        r = MISS_PT;
        if (idx >= count) begin
            return r;
        end

        n = longint'(1) << lvl;
        off = idx & (per_face - 1);
        face = 0;
        if (cube_shadow) begin
            face = idx >> (2 * lvl);
            // faces from the negative z face on walk their offsets backwards
            if (face >= FACE_ZN) begin
                off = per_face - 1 - off;
            end
        end

        // digits from the top, lower ones complemented under quadrants 0 and 3
        flip = 2'b00;
        for (k = lvl; k >= 1; k--) begin
            q = 2'(off >> (2 * (k - 1))) ^ flip;
            quad[k] = q;
            if (q == QUAD_LL || q == QUAD_LR) begin
                flip = flip ^ 2'b11;
            end
        end

        // place the sub point level by level from the bottom
        u = 0;
        v = 0;
        for (k = 1; k <= lvl; k++) begin
            s = longint'(1) << (k - 1);
            case (quad[k])
                QUAD_LL: begin
                    nu = v;
                    nv = s - 1 - u;
                end
                QUAD_UL: begin
                    nu = u;
                    nv = v + s;
                end
                QUAD_UR: begin
                    nu = u + s;
                    nv = v + s;
                end
                default: begin
                    nu = 2 * s - 1 - v;
                    nv = u;
                end
            endcase
            u = nu;
            v = nv;
        end

        px = 2 * u + 1 - n;
        py = 2 * v + 1 - n;
        if (!cube_shadow) begin
            cx = px;
            cy = py;
            cz = 0;
        end else begin
            case (FACE_W'(face))
                FACE_YP: begin
                    cx = px;
                    cy = n;
                    cz = py;
                end
                FACE_XP: begin
                    cx = n;
                    cy = -px;
                    cz = py;
                end
                FACE_ZN: begin
                    cx = px;
                    cy = py;
                    cz = -n;
                end
                FACE_XN: begin
                    cx = -n;
                    cy = py;
                    cz = -px;
                end
                FACE_ZP: begin
                    cx = -px;
                    cy = py;
                    cz = n;
                end
                default: begin
                    cx = px;
                    cy = -n;
                    cz = -py;
                end
            endcase
        end

        r.coord_x     = COORD_W'(cx);
        r.coord_y     = COORD_W'(cy);
        r.coord_z     = COORD_W'(cz);
        r.face_number = FACE_W'(face);
        r.in_range    = 1'b1;
        return r;
    endfunction

    // random index: mostly inside the curve, some around the point count, some raw noise
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned     lvl;
        int unsigned     roll;
        longint unsigned count;

        lvl = (lvl_shadow > MAX_LEVEL) ? MAX_LEVEL : lvl_shadow;
        count = (longint'(1) << (2 * lvl)) * (cube_shadow ? 6 : 1);
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return IDX_W'($urandom_range(0, int'(count - 1)));
        end else if (roll < 90) begin
            return IDX_W'(count - 2 + $urandom_range(0, 3));
        end else begin
            return IDX_W'($urandom);
        end
    endfunction

    // offer one index beat; valid stays high across back to back beats
    task automatic send_point(input logic [IDX_W-1:0] idx, input t_point exp_pt);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            pt_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_in.valid       <= 1'b1;
        pt_in.point_index <= idx;
        @(posedge i_clk);
        while (!pt_in.ready) begin
            @(posedge i_clk);
        end
        pending_points.insert(pending_points.size(), exp_pt);
    endtask

    // drop valid and wait until every expected point has come out
    task automatic settle();
        pt_in.valid <= 1'b0;
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write both registers back to back; unused upper bits of the cube data are random
    task automatic write_config(input logic [LVL_W-1:0] lvl_data, input logic cube_bit);
        logic [CFG_DAT_W-1:0] cube_data;

        cube_data    = CFG_DAT_W'($urandom);
        cube_data[0] = cube_bit;
        cfg_wr.valid     <= 1'b1;
        cfg_wr.reg_index <= CFG_LEVEL;
        cfg_wr.wr_data   <= CFG_DAT_W'(lvl_data);
        @(posedge i_clk);
        while (!cfg_wr.ready) begin
            @(posedge i_clk);
        end
        lvl_shadow = lvl_data;
        cfg_wr.reg_index <= CFG_CUBE;
        cfg_wr.wr_data   <= cube_data;
        @(posedge i_clk);
        while (!cfg_wr.ready) begin
            @(posedge i_clk);
        end
        cube_shadow = cube_data[0];
        cfg_wr.valid <= 1'b0;
    endtask

    // output side: random ready, plus one long hold-off so the pipe fills and backs up
    initial begin : sink_side
        int hold_left;

        hold_left = 0;
        pt_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pt_out.ready <= 1'b0;
            end else begin
                pt_out.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        t_point exp_pt;

        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            if (pending_points.size() == 0) begin
                bad_beats++;
                if (bad_beats <= REPORT_MAX) begin
                    $display("unexpected output beat: x %0d y %0d z %0d face %0d in_range %0b",
                             pt_out.coord_x, pt_out.coord_y, pt_out.coord_z,
                             pt_out.face_number, pt_out.in_range);
                end
            end else begin
                exp_pt = pending_points.pop_front();
                if (pt_out.coord_x !== exp_pt.coord_x || pt_out.coord_y !== exp_pt.coord_y
                    || pt_out.coord_z !== exp_pt.coord_z
                    || pt_out.face_number !== exp_pt.face_number
                    || pt_out.in_range !== exp_pt.in_range) begin
                    bad_beats++;
                    if (bad_beats <= REPORT_MAX) begin
                        $display("point mismatch: exp x %0d y %0d z %0d face %0d in_range %0b",
                                 exp_pt.coord_x, exp_pt.coord_y, exp_pt.coord_z,
                                 exp_pt.face_number, exp_pt.in_range);
                        $display("                got x %0d y %0d z %0d face %0d in_range %0b",
                                 pt_out.coord_x, pt_out.coord_y, pt_out.coord_z,
                                 pt_out.face_number, pt_out.in_range);
                    end
                end
            end
        end
    end

    // watchdog on a cycle count
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus: reset, directed table, random phases, final drain and verdict
    initial begin : stimulus
        t_point           exp_pt;
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] lvl_pick;
        logic             cube_pick;

        i_rst_n           <= 1'b0;
        pt_in.valid       <= 1'b0;
        pt_in.point_index <= '0;
        cfg_wr.valid      <= 1'b0;
        cfg_wr.reg_index  <= CFG_LEVEL;
        cfg_wr.wr_data    <= '0;
        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; settings change only with the pipe empty
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].level != lvl_shadow || DIR_TABLE[r].cube != cube_shadow) begin
                settle();
                write_config(DIR_TABLE[r].level, DIR_TABLE[r].cube);
            end
            exp_pt = DIR_TABLE[r].typed ? DIR_TABLE[r].lit : plot_point(DIR_TABLE[r].idx);
            send_point(DIR_TABLE[r].idx, exp_pt);
        end

        // random phases, each under its own settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 8) begin
                lvl_pick  = PHASE_LEVEL[ph];
                cube_pick = PHASE_CUBE[ph];
            end else begin
                lvl_pick  = LVL_W'($urandom_range(0, 15));
                cube_pick = 1'($urandom_range(0, 1));
            end
            settle();
            write_config(lvl_pick, cube_pick);
            // one phase runs flat out on both sides
            idle_on = (ph != NO_IDLE_PHASE);
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                idx = pick_index();
                send_point(idx, plot_point(idx));
            end
        end

        // drain, then give stray beats a chance to show up
        settle();
        repeat (2 * PIPE_DEPTH) begin
            @(posedge i_clk);
        end

        if (bad_beats == 0 && pending_points.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
